// ----- design/irfd_pkg.sv -----
// Shared types and constants for the IR remote frame decoder.
// No dependencies; used by irfd_engine and the top level.
package irfd_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_START_LOW     = 2'd0,
      REG_START_HIGH    = 2'd1,
      REG_BIT_DELAY     = 2'd2,
      REG_FRAME_TIMEOUT = 2'd3
   } reg_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_NEW    = 2'd0,
      STATUS_REPEAT = 2'd1,
      STATUS_REJECT = 2'd2
   } frame_status_type;

   // Reset values of the configuration registers.
   localparam logic [15:0] START_LOW_RESET     = 16'd700;
   localparam logic [15:0] START_HIGH_RESET    = 16'd300;
   localparam logic [15:0] BIT_DELAY_RESET     = 16'd80;
   localparam logic [15:0] FRAME_TIMEOUT_RESET = 16'd10000;

   // Frame byte checks.
   localparam logic [7:0] HEADER_BYTE0 = 8'hFF;
   localparam logic [7:0] HEADER_BYTE1 = 8'h00;
   localparam logic [7:0] CHECK_XOR    = 8'hFF;

   // Counter increment that holds at all ones.
   function automatic logic [15:0] sat_inc(input logic [15:0] value);
      logic [15:0] result;
      result = (value == 16'hFFFF) ? value : value + 16'd1;
      return result;
   endfunction

endpackage

// ----- design/irfd_queue.sv -----
// Short FIFO of pin samples between the accepting front and the decode engine.
// No package dependencies.
module irfd_queue #(
   parameter int DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_stall,
   input  logic push_level,
   output logic pop_valid,
   input  logic pop_ready,
   output logic pop_level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic             data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   // Handshake: full queue stalls the sender, any entry is offered to the engine.
   assign push_stall = (count_ff == FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_level  = data_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Sample storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_level;
      end
   end

endmodule

// ----- design/irfd_engine.sv -----
// Frame decode engine: timing state machine, byte assembly and result register.
// Depends on irfd_pkg.
module irfd_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  irfd_pkg::reg_index_type    csr_index,
   input  logic [15:0]                csr_wdata,
   input  logic                       sample_valid,
   output logic                       sample_ready,
   input  logic                       sample_level,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_key_code,
   output logic [1:0]                 rsp_frame_status
);

   import irfd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_START_LOW  = 3'd1,
      PH_START_HIGH = 3'd2,
      PH_MARK       = 3'd3,
      PH_DELAY      = 3'd4,
      PH_SPACE      = 3'd5
   } phase_type;

   logic [15:0] start_low_ff, start_high_ff, bit_delay_ff, frame_timeout_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] phase_ticks_ff, phase_ticks_in;
   logic [15:0] frame_ticks_ff, frame_ticks_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  previous_ff, previous_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_key_code_ff, rsp_key_code_in;
   logic [1:0]  rsp_frame_status_ff, rsp_frame_status_in;

   logic        step;
   logic        emit;
   logic [7:0]  emit_code;
   frame_status_type emit_status;
   logic [15:0] frame_dec;
   logic        expired;
   logic [15:0] delay_ticks;
   logic        bit_value;
   logic [7:0]  shifted;

   // A sample is taken whenever the result register is free or being drained.
   assign sample_ready = !rsp_valid_ff || !rsp_stall;
   assign step         = sample_valid && sample_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = rsp_key_code_ff;
   assign rsp_frame_status = rsp_frame_status_ff;

   // Shared terms of the data phases.
   assign frame_dec   = (frame_ticks_ff != '0) ? frame_ticks_ff - 16'd1 : frame_ticks_ff;
   assign expired     = (frame_dec == '0);
   assign delay_ticks = sat_inc(phase_ticks_ff);
   assign bit_value   = !sample_level;
   assign shifted     = {shift_ff[6:0], bit_value};

   // Next state of the decoder for one sample.
   always_comb begin
      phase_in       = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      frame_ticks_in = frame_ticks_ff;
      shift_in       = shift_ff;
      bit_count_in   = bit_count_ff;
      byte_index_in  = byte_index_ff;
      command_in     = command_ff;
      previous_in    = previous_ff;
      emit           = 1'b0;
      emit_code      = '0;
      emit_status    = STATUS_REJECT;

      unique case (phase_ff)
         PH_IDLE: begin
            if (!sample_level) begin
               phase_in       = PH_START_LOW;
               phase_ticks_in = 16'd1;
            end
         end
         PH_START_LOW: begin
            if (!sample_level) begin
               phase_ticks_in = sat_inc(phase_ticks_ff);
            end else if (phase_ticks_ff < start_low_ff) begin
               emit = 1'b1;
            end else begin
               phase_in       = PH_START_HIGH;
               phase_ticks_in = 16'd1;
            end
         end
         PH_START_HIGH: begin
            if (sample_level) begin
               phase_ticks_in = sat_inc(phase_ticks_ff);
            end else if (phase_ticks_ff < start_high_ff) begin
               emit = 1'b1;
            end else begin
               phase_in       = PH_MARK;
               phase_ticks_in = '0;
               frame_ticks_in = frame_timeout_ff;
               shift_in       = '0;
               bit_count_in   = '0;
               byte_index_in  = '0;
            end
         end
         PH_MARK: begin
            frame_ticks_in = frame_dec;
            if (expired || sample_level) begin
               phase_in       = PH_DELAY;
               phase_ticks_in = '0;
            end
         end
         PH_SPACE: begin
            frame_ticks_in = frame_dec;
            if (expired) begin
               phase_in       = PH_DELAY;
               phase_ticks_in = '0;
            end else if (!sample_level) begin
               phase_in = PH_MARK;
            end
         end
         PH_DELAY: begin
            frame_ticks_in = frame_dec;
            phase_ticks_in = delay_ticks;
            if (delay_ticks >= bit_delay_ff) begin
               // Sample the bit and move on to the next mark or space.
               shift_in       = shifted;
               bit_count_in   = bit_count_ff + 3'd1;
               phase_in       = bit_value ? PH_MARK : PH_SPACE;
               phase_ticks_in = '0;
               if (bit_count_ff == 3'd7) begin
                  // A whole byte is in: check it by its place in the frame.
                  unique case (byte_index_ff)
                     2'd0: begin
                        if (shifted != HEADER_BYTE0) begin
                           emit = 1'b1;
                        end else begin
                           byte_index_in = byte_index_ff + 2'd1;
                           shift_in      = '0;
                        end
                     end
                     2'd1: begin
                        if (shifted != HEADER_BYTE1) begin
                           emit = 1'b1;
                        end else begin
                           byte_index_in = byte_index_ff + 2'd1;
                           shift_in      = '0;
                        end
                     end
                     2'd2: begin
                        command_in    = shifted;
                        byte_index_in = byte_index_ff + 2'd1;
                        shift_in      = '0;
                     end
                     default: begin
                        emit = 1'b1;
                        if ((shifted ^ command_ff) != CHECK_XOR) begin
                           emit_status = STATUS_REJECT;
                        end else if (!expired) begin
                           previous_in = command_ff;
                           emit_code   = command_ff;
                           emit_status = STATUS_NEW;
                        end else begin
                           emit_code   = previous_ff;
                           emit_status = STATUS_REPEAT;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            phase_in       = PH_IDLE;
            phase_ticks_in = '0;
         end
      endcase

      // Any result sends the decoder back to idle.
      if (emit) begin
         phase_in       = PH_IDLE;
         phase_ticks_in = '0;
      end
   end

   // Result register: loaded by a result, emptied when the receiver takes it.
   always_comb begin
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_key_code_in     = rsp_key_code_ff;
      rsp_frame_status_in = rsp_frame_status_ff;
      if (step && emit) begin
         rsp_valid_in        = 1'b1;
         rsp_key_code_in     = emit_code;
         rsp_frame_status_in = emit_status;
      end
   end

   // Decoder state, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff        <= START_LOW_RESET;
         start_high_ff       <= START_HIGH_RESET;
         bit_delay_ff        <= BIT_DELAY_RESET;
         frame_timeout_ff    <= FRAME_TIMEOUT_RESET;
         phase_ff            <= PH_IDLE;
         phase_ticks_ff      <= '0;
         frame_ticks_ff      <= '0;
         shift_ff            <= '0;
         bit_count_ff        <= '0;
         byte_index_ff       <= '0;
         command_ff          <= '0;
         previous_ff         <= '0;
         rsp_valid_ff        <= 1'b0;
         rsp_key_code_ff     <= '0;
         rsp_frame_status_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_START_LOW:     start_low_ff     <= csr_wdata;
               REG_START_HIGH:    start_high_ff    <= csr_wdata;
               REG_BIT_DELAY:     bit_delay_ff     <= csr_wdata;
               REG_FRAME_TIMEOUT: frame_timeout_ff <= csr_wdata;
               default:           start_low_ff     <= start_low_ff;
            endcase
         end
         if (step) begin
            phase_ff       <= phase_in;
            phase_ticks_ff <= phase_ticks_in;
            frame_ticks_ff <= frame_ticks_in;
            shift_ff       <= shift_in;
            bit_count_ff   <= bit_count_in;
            byte_index_ff  <= byte_index_in;
            command_ff     <= command_in;
            previous_ff    <= previous_in;
         end
         rsp_valid_ff        <= rsp_valid_in;
         rsp_key_code_ff     <= rsp_key_code_in;
         rsp_frame_status_ff <= rsp_frame_status_in;
      end
   end

endmodule

// ----- design/ir_remote_frame_decoder_core.sv -----
// Top level of the IR remote frame decoder.
// Depends on irfd_pkg, irfd_queue and irfd_engine.

// Decodes NEC style frames from an active-low IR receiver pin, one pin sample
// per word on the req channel. Each frame yields one word on the rsp channel:
// a new key code, the stored code for a frame that finished after the timeout,
// or code 0 with a reject status. The block takes one sample per clock cycle
// unless the output register is full and stalled; a sample waits in the queue
// until the engine takes it, and its result is registered as it is taken.
// The sample queue (QUEUE_DEPTH words) lets the sender keep going while a
// result waits to be taken; the engine pauses only while the output register
// is full and stalled. Timing registers are written through the csr port,
// which is always ready; write them only while no frame is in progress.
module ir_remote_frame_decoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  irfd_pkg::reg_index_type csr_index,
   input  logic [15:0]             csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_pin_level,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_key_code,
   output logic [1:0]              rsp_frame_status
);

   import irfd_pkg::*;

   logic sample_valid;
   logic sample_ready;
   logic sample_level;

   // Configuration writes never wait.
   assign csr_ready = 1'b1;

   // Front: accepts pin samples into the queue.
   irfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_level (req_pin_level),
      .pop_valid  (sample_valid),
      .pop_ready  (sample_ready),
      .pop_level  (sample_level)
   );

   // Back: frame decoding and result register.
   irfd_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .sample_valid     (sample_valid),
      .sample_ready     (sample_ready),
      .sample_level     (sample_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for ir_remote_frame_decoder_core: pin sample streams in, key words out.
// Depends on irfd_pkg and the decoder RTL; a built-in frame decoder predicts every result word.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import irfd_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int SETTLE_CYCLES = 10;
   localparam int GAP_PERCENT = 37;

   // Expected result word.
   typedef struct packed {
      logic [7:0]       code;
      frame_status_type status;
   } key_result_type;

   // Decoder phases of the predictor.
   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_START_MARK,
      DEC_START_SPACE,
      DEC_MARK,
      DEC_DELAY,
      DEC_SPACE
   } decode_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic           csr_valid = 1'b0;
   logic           csr_ready;
   reg_index_type  csr_index = REG_START_LOW;
   logic [15:0]    csr_wdata = 16'd0;
   logic           req_valid = 1'b0;
   logic           req_stall;
   logic           req_pin_level = 1'b1;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic [7:0]     rsp_key_code;
   logic [1:0]     rsp_frame_status;

   // Timing registers as the predictor sees them, indexed by register index.
   logic [15:0] timing_regs [4] = '{START_LOW_RESET, START_HIGH_RESET,
                                    BIT_DELAY_RESET, FRAME_TIMEOUT_RESET};

   // Predictor state.
   decode_phase_type dec_phase = DEC_IDLE;
   logic [15:0]   phase_count = 16'd0;
   logic [15:0]   budget_left = 16'd0;
   logic [7:0]    shift_reg = 8'd0;
   logic [2:0]    bits_in_byte = 3'd0;
   logic [1:0]    byte_pos = 2'd0;
   logic [7:0]    command_code = 8'd0;
   logic [7:0]    stored_code = 8'd0;

   logic             pin_samples [$];
   key_result_type   expected_keys [$];
   logic [7:0]       pred_code;
   frame_status_type pred_status;
   bit               pred_has_key;
   key_result_type   oldest_key;
   bit               no_gaps = 1'b0;
   int               error_count = 0;
   int               cycle_count = 0;

   ir_remote_frame_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_frame_status (rsp_frame_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(input string text);
      $display("MISMATCH at cycle %0d: %s", cycle_count, text);
      error_count++;
   endtask

   // Ends the current frame with a result word and returns to idle.
   function automatic bit close_frame(input logic [7:0] value, input frame_status_type kind,
                                      output logic [7:0] code, output frame_status_type status);
      code = value;
      status = kind;
      dec_phase = DEC_IDLE;
      phase_count = 16'd0;
      return 1'b1;
   endfunction

   // Advances the predicted decoder by one pin sample; returns 1 when a word results.
   function automatic bit decode_sample(input logic high, output logic [7:0] code,
                                        output frame_status_type status);
      logic expired;
      logic bit_value;
      code = 8'h00;
      status = STATUS_NEW;
      case (dec_phase)
         DEC_IDLE: begin
            if (!high) begin
               dec_phase = DEC_START_MARK;
               phase_count = 16'd1;
            end
            return 1'b0;
         end
         DEC_START_MARK: begin
            if (!high) begin
               if (phase_count != 16'hFFFF) phase_count = phase_count + 16'd1;
               return 1'b0;
            end
            if (phase_count < timing_regs[REG_START_LOW])
               return close_frame(8'h00, STATUS_REJECT, code, status);
            dec_phase = DEC_START_SPACE;
            phase_count = 16'd1;
            return 1'b0;
         end
         DEC_START_SPACE: begin
            if (high) begin
               if (phase_count != 16'hFFFF) phase_count = phase_count + 16'd1;
               return 1'b0;
            end
            if (phase_count < timing_regs[REG_START_HIGH])
               return close_frame(8'h00, STATUS_REJECT, code, status);
            // This low sample is already the first data mark.
            dec_phase = DEC_MARK;
            phase_count = 16'd0;
            budget_left = timing_regs[REG_FRAME_TIMEOUT];
            shift_reg = 8'd0;
            bits_in_byte = 3'd0;
            byte_pos = 2'd0;
            return 1'b0;
         end
         default: ;
      endcase

      // Data phase: the frame budget counts down first and holds at zero.
      if (budget_left != 16'd0) budget_left = budget_left - 16'd1;
      expired = (budget_left == 16'd0);

      if (dec_phase == DEC_MARK) begin
         if (expired || high) begin
            dec_phase = DEC_DELAY;
            phase_count = 16'd0;
         end
         return 1'b0;
      end
      if (dec_phase == DEC_SPACE) begin
         if (expired) begin
            dec_phase = DEC_DELAY;
            phase_count = 16'd0;
         end else if (!high) begin
            dec_phase = DEC_MARK;
         end
         return 1'b0;
      end

      // Bit sample point after the mark end.
      if (phase_count != 16'hFFFF) phase_count = phase_count + 16'd1;
      if (phase_count < timing_regs[REG_BIT_DELAY]) return 1'b0;
      bit_value = !high;
      shift_reg = {shift_reg[6:0], bit_value};
      bits_in_byte = bits_in_byte + 3'd1;
      dec_phase = bit_value ? DEC_MARK : DEC_SPACE;
      phase_count = 16'd0;
      if (bits_in_byte != 3'd0) return 1'b0;

      case (byte_pos)
         2'd0: if (shift_reg != 8'hFF) return close_frame(8'h00, STATUS_REJECT, code, status);
         2'd1: if (shift_reg != 8'h00) return close_frame(8'h00, STATUS_REJECT, code, status);
         2'd2: command_code = shift_reg;
         default: begin
            if ((shift_reg ^ command_code) != 8'hFF)
               return close_frame(8'h00, STATUS_REJECT, code, status);
            if (!expired) begin
               stored_code = command_code;
               return close_frame(command_code, STATUS_NEW, code, status);
            end
            return close_frame(stored_code, STATUS_REPEAT, code, status);
         end
      endcase
      byte_pos = byte_pos + 2'd1;
      shift_reg = 8'd0;
      return 1'b0;
   endfunction

   // Sender: presents queued pin samples and predicts each accepted word.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pred_has_key = decode_sample(req_pin_level, pred_code, pred_status);
            if (pred_has_key) expected_keys.push_back('{pred_code, pred_status});
         end
         if (!req_valid || !req_stall) begin
            if (pin_samples.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
               req_valid <= 1'b1;
               req_pin_level <= pin_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls and comparison against the oldest expected word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_keys.size() == 0) begin
               flag_error($sformatf("unexpected word: code %02h status %0d",
                                    rsp_key_code, rsp_frame_status));
            end else begin
               oldest_key = expected_keys.pop_front();
               if (rsp_key_code !== oldest_key.code)
                  flag_error($sformatf("key_code %02h, expected %02h",
                                       rsp_key_code, oldest_key.code));
               if (rsp_frame_status !== oldest_key.status)
                  flag_error($sformatf("frame_status %0d, expected %0d",
                                       rsp_frame_status, oldest_key.status));
            end
         end
         rsp_stall <= !no_gaps && ($urandom_range(99) < GAP_PERCENT);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, expected_keys.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] remote_word(input logic [7:0] command);
      return {8'hFF, 8'h00, command, ~command};
   endfunction

   task automatic push_run(input logic level, input int unsigned count);
      repeat (count) pin_samples.push_back(level);
   endtask

   // Well-formed frame: each bit is a mark, then a space that ends exactly at the
   // sample point for a one, or runs past it for a zero.
   task automatic push_frame(input logic [31:0] bytes, input int unsigned mark_len,
                             input int unsigned space_len, input int unsigned trail);
      int unsigned delay_len;
      delay_len = (timing_regs[REG_BIT_DELAY] == 16'd0) ? 1 : timing_regs[REG_BIT_DELAY];
      push_run(1'b0, mark_len);
      push_run(1'b1, space_len);
      for (int i = 31; i >= 0; i--) begin
         push_run(1'b0, $urandom_range(1, 4));
         push_run(1'b1, bytes[i] ? delay_len : delay_len + $urandom_range(1, 3));
      end
      // A final one is sampled on a low level.
      if (bytes[0]) pin_samples.push_back(1'b0);
      push_run(1'b1, trail);
   endtask

   // Frame for an already expired budget: every bit takes one idle tick plus the
   // bit delay, and only the last sample of each bit matters.
   task automatic push_late_frame(input logic [31:0] bytes, input int unsigned mark_len,
                                  input int unsigned space_len);
      int unsigned delay_len;
      delay_len = (timing_regs[REG_BIT_DELAY] == 16'd0) ? 1 : timing_regs[REG_BIT_DELAY];
      push_run(1'b0, mark_len);
      push_run(1'b1, space_len);
      pin_samples.push_back(1'b0);
      for (int i = 31; i >= 0; i--) begin
         repeat (delay_len) pin_samples.push_back(1'($urandom_range(1)));
         pin_samples.push_back(!bytes[i]);
      end
      push_run(1'b1, 4);
   endtask

   // One random piece of traffic: mostly frames with random content.
   task automatic add_random_segment();
      int unsigned pick;
      logic [7:0]  command;
      logic [31:0] bytes;
      int unsigned mark_len;
      int unsigned space_len;
      pick = $urandom_range(99);
      command = 8'($urandom_range(255));
      bytes = remote_word(command);
      if ($urandom_range(99) < 8) bytes[31:24] = 8'($urandom_range(255));
      if ($urandom_range(99) < 8) bytes[23:16] = 8'($urandom_range(255));
      if ($urandom_range(99) < 10) bytes[7:0] = 8'($urandom_range(255));
      mark_len = timing_regs[REG_START_LOW] + $urandom_range(3);
      space_len = timing_regs[REG_START_HIGH] + $urandom_range(3);
      if (pick < 70) begin
         push_frame(bytes, mark_len, space_len, $urandom_range(0, 6));
      end else if (pick < 80 && timing_regs[REG_START_LOW] > 16'd1) begin
         push_run(1'b0, $urandom_range(1, timing_regs[REG_START_LOW] - 1));
         push_run(1'b1, $urandom_range(1, 4));
      end else if (pick < 88 && timing_regs[REG_START_HIGH] > 16'd1) begin
         push_run(1'b0, mark_len);
         push_run(1'b1, $urandom_range(1, timing_regs[REG_START_HIGH] - 1));
         push_run(1'b0, 1);
         push_run(1'b1, 3);
      end else begin
         repeat ($urandom_range(1, 40)) pin_samples.push_back(1'($urandom_range(1)));
      end
   endtask

   // Waits until all samples are taken, the predicted decoder is idle and every
   // expected word has arrived. An open start space is closed by one low sample,
   // any other open frame by idle level.
   task automatic settle();
      do begin
         do @(negedge clock); while (pin_samples.size() != 0 || req_valid);
         if (dec_phase == DEC_START_SPACE) pin_samples.push_back(1'b0);
         else if (dec_phase != DEC_IDLE) push_run(1'b1, 64);
      end while (dec_phase != DEC_IDLE);
      do @(negedge clock); while (expected_keys.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      timing_regs[index] = value;
      @(posedge clock);
   endtask

   task automatic program_timing(input logic [15:0] low_ticks, input logic [15:0] high_ticks,
                                 input logic [15:0] delay_ticks, input logic [15:0] budget);
      write_reg(REG_START_LOW, low_ticks);
      write_reg(REG_START_HIGH, high_ticks);
      write_reg(REG_BIT_DELAY, delay_ticks);
      write_reg(REG_FRAME_TIMEOUT, budget);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A start mark one tick short of the reset minimum is rejected.
      push_run(1'b0, 699);
      push_run(1'b1, 4);
      settle();

      // Short timing: start errors, header and check errors, edge codes.
      program_timing(16'd3, 16'd2, 16'd2, 16'd1000);
      push_run(1'b0, 2);
      push_run(1'b1, 3);
      push_run(1'b0, 3);
      push_run(1'b1, 1);
      push_run(1'b0, 1);
      push_run(1'b1, 3);
      push_frame({8'hFE, 8'h00, 8'h12, 8'hED}, 3, 2, 3);
      push_frame({8'hFF, 8'h01, 8'h12, 8'hED}, 3, 2, 3);
      push_frame({8'hFF, 8'h00, 8'h12, 8'h12}, 4, 3, 3);
      push_frame(remote_word(8'h00), 3, 2, 3);
      push_frame(remote_word(8'hFF), 4, 5, 3);
      // The pin stays low after the last bit and opens the next start mark.
      push_frame(remote_word(8'h80), 3, 2, 0);
      push_frame(remote_word(8'h81), 3, 2, 3);
      settle();

      // Budget of one tick: a late frame repeats the stored code, one with a bad check byte is rejected.
      program_timing(16'd3, 16'd2, 16'd2, 16'd1);
      push_late_frame(remote_word(8'h33), 3, 2);
      push_late_frame({8'hFF, 8'h00, 8'h33, 8'h33}, 3, 2);
      settle();

      // Random traffic under several timings.
      program_timing(16'd4, 16'd3, 16'd2, 16'd250);
      repeat (2) add_random_segment();
      settle();

      no_gaps = 1'b1;
      program_timing(16'd1, 16'd1, 16'd1, 16'd2000);
      repeat (2) add_random_segment();
      settle();
      no_gaps = 1'b0;

      program_timing(16'd6, 16'd2, 16'd3, 16'd120);
      repeat (2) add_random_segment();
      settle();

      program_timing(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                     16'($urandom_range(1, 3)), 16'($urandom_range(60, 400)));
      repeat (2) add_random_segment();
      settle();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
